// ===== sv/kip_pkg.sv =====
package kip_pkg;

	// register indexes of the configuration port
	localparam logic [7:0] REG_LENGTH = 8'd0;
	localparam logic [7:0] REG_SEED   = 8'd1;

	localparam int NUM_OPS  = 36;
	localparam int OP_W     = 6;
	localparam int DIV_W    = 6;

	typedef enum logic [2:0] {
		OP_XS,   // v ^= seed >> sh
		OP_XM,   // v ^= (v & mask) >> sh
		OP_MUL,  // v *= constant
		OP_MULS, // v *= (seed >> 27) | 1
		OP_AND   // v &= mask
	} op_kind_t;

	typedef struct packed {
		op_kind_t    kind;
		logic [5:0]  sh;
		logic [63:0] k;
	} op_t;

	typedef struct packed {
		logic            load;     // take a new index
		logic            zero;     // answer zero, length is zero
		logic            div_step; // one remainder step
		logic            fix;      // wrap remainder into range
		logic            mix;      // run one op of the mix pass
		logic [OP_W-1:0] op_idx;
		logic [1:0]      mul_ph;   // partial product of a 64-bit multiply
	} cmd_t;

	typedef struct packed {
		logic len_zero;
		logic below_len;
	} sts_t;

	function automatic op_t mk(op_kind_t kind, logic [5:0] sh, logic [63:0] k);
		op_t o;
		o.kind = kind;
		o.sh   = sh;
		o.k    = k;
		return o;
	endfunction

	// program of one mix pass, one op per index
	function automatic op_t op_rom(logic [OP_W-1:0] idx);
		op_t o;
		unique case (idx)
			6'd0:  o = mk(OP_XS,   6'd0,  64'd0);
			6'd1:  o = mk(OP_XM,   6'd30, 64'd0);
			6'd2:  o = mk(OP_MUL,  6'd0,  64'hBF58476D1CE4E5B9);
			6'd3:  o = mk(OP_XM,   6'd27, 64'd0);
			6'd4:  o = mk(OP_MUL,  6'd0,  64'h94D049BB133111EB);
			6'd5:  o = mk(OP_XM,   6'd31, 64'd0);
			6'd6:  o = mk(OP_MUL,  6'd0,  64'hBF58476D1CE4E5B9);
			6'd7:  o = mk(OP_XS,   6'd32, 64'd0);
			6'd8:  o = mk(OP_AND,  6'd0,  64'd0);
			6'd9:  o = mk(OP_MUL,  6'd0,  64'h00000000ED5AD4BB);
			6'd10: o = mk(OP_XS,   6'd48, 64'd0);
			6'd11: o = mk(OP_XM,   6'd7,  64'd0);
			6'd12: o = mk(OP_MUL,  6'd0,  64'h0000000000002993);
			6'd13: o = mk(OP_XM,   6'd5,  64'd0);
			6'd14: o = mk(OP_MUL,  6'd0,  64'h000000000000E877);
			6'd15: o = mk(OP_XM,   6'd9,  64'd0);
			6'd16: o = mk(OP_MUL,  6'd0,  64'h0000000000000235);
			6'd17: o = mk(OP_XM,   6'd10, 64'd0);
			6'd18: o = mk(OP_XS,   6'd0,  64'd0);
			6'd19: o = mk(OP_MUL,  6'd0,  64'h00000000E170893D);
			6'd20: o = mk(OP_XS,   6'd16, 64'd0);
			6'd21: o = mk(OP_XM,   6'd4,  64'd0);
			6'd22: o = mk(OP_XS,   6'd8,  64'd0);
			6'd23: o = mk(OP_MUL,  6'd0,  64'h000000000929EB3F);
			6'd24: o = mk(OP_XS,   6'd23, 64'd0);
			6'd25: o = mk(OP_XM,   6'd1,  64'd0);
			6'd26: o = mk(OP_MULS, 6'd0,  64'd0);
			6'd27: o = mk(OP_MUL,  6'd0,  64'h000000006935FA69);
			6'd28: o = mk(OP_XM,   6'd11, 64'd0);
			6'd29: o = mk(OP_MUL,  6'd0,  64'h0000000074DCB303);
			6'd30: o = mk(OP_XM,   6'd2,  64'd0);
			6'd31: o = mk(OP_MUL,  6'd0,  64'h000000009E501CC3);
			6'd32: o = mk(OP_XM,   6'd2,  64'd0);
			6'd33: o = mk(OP_MUL,  6'd0,  64'h00000000C860A3DF);
			6'd34: o = mk(OP_AND,  6'd0,  64'd0);
			6'd35: o = mk(OP_XM,   6'd5,  64'd0);
			default: o = mk(OP_AND, 6'd0, 64'd0);
		endcase
		return o;
	endfunction

endpackage

// ===== sv/keyed_index_permutation_top.sv =====
// Keyed index permutation: maps a signed 64-bit index to a position below
// the configured length, a keyed bijection of 0..length-1.
// Input: pulse start with source_index while busy is low; the word is taken
// at that edge and busy rises on the next cycle.
// Output: done is high for exactly one cycle with permuted_index valid;
// the receiver cannot stall it, so it must take the word in that cycle.
// Configuration: cfg_valid/cfg_ready write channel, always ready.
// Index 0 writes the length (data bits 62:0), index 1 the 64-bit seed;
// other indexes are dropped. Write only while busy is low.
// Sequence: a bit-serial remainder, then the wrap state, then mix passes
// (14 multiplies on one 32x32 multiplier, 22 other ops, one range check)
// repeated while the value is out of range, then the done state.
// A zero length answers 0 in the cycle right after the accept.
// Reset: length 1, seed 0, controller idle.
module keyed_index_permutation_top (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               start,
	output logic               busy,
	input  logic signed [63:0] source_index,
	output logic               done,
	output logic [62:0]        permuted_index,
	input  logic               cfg_valid,
	output logic               cfg_ready,
	input  logic [7:0]         cfg_index,
	input  logic [63:0]        cfg_data
);

	kip_pkg::cmd_t cmd;
	kip_pkg::sts_t sts;

	assign cfg_ready = 1'b1;

	kip_ctrl u_ctrl (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.busy   (busy),
		.done   (done),
		.cmd    (cmd),
		.sts    (sts)
	);

	kip_dp u_dp (
		.clk            (clk),
		.arst_n         (arst_n),
		.cmd            (cmd),
		.sts            (sts),
		.source_index   (source_index),
		.cfg_we         (cfg_valid && cfg_ready),
		.cfg_index      (cfg_index),
		.cfg_data       (cfg_data),
		.permuted_index (permuted_index)
	);

endmodule

// ===== sv/kip_dp.sv =====
module kip_dp (
	input  logic               clk,
	input  logic               arst_n,
	input  kip_pkg::cmd_t      cmd,
	output kip_pkg::sts_t      sts,
	input  logic signed [63:0] source_index,
	input  logic               cfg_we,
	input  logic [7:0]         cfg_index,
	input  logic [63:0]        cfg_data,
	output logic [62:0]        permuted_index
);

	logic [62:0] len_q;
	logic [63:0] seed_q;
	logic [62:0] mask_q;
	logic [63:0] v_q;
	logic [63:0] rem_q;
	logic [63:0] dvd_q;
	logic        neg_q;
	logic [63:0] acc_q;

	kip_pkg::op_t op;
	logic [63:0] len_w;
	logic [63:0] mask_w;
	logic [63:0] trial;
	logic [63:0] mul_b;
	logic [31:0] mul_x;
	logic [31:0] mul_y;
	logic [63:0] prod;
	logic [63:0] v_nxt;

	function automatic logic [62:0] make_mask(logic [62:0] len);
		logic [62:0] m;
		m = len - 63'd1;
		m = m | (m >> 1);
		m = m | (m >> 2);
		m = m | (m >> 4);
		m = m | (m >> 8);
		m = m | (m >> 16);
		m = m | (m >> 32);
		return (len == 63'd0) ? 63'd0 : m;
	endfunction

	assign len_w  = {1'b0, len_q};
	assign mask_w = {1'b0, mask_q};
	assign op     = kip_pkg::op_rom(cmd.op_idx);
	assign trial  = {rem_q[62:0], dvd_q[63]};

	assign sts.len_zero  = (len_q == 63'd0);
	assign sts.below_len = (v_q < len_w);
	assign permuted_index = v_q[62:0];

	// pick one 32x32 partial product per cycle
	always_comb begin
		mul_b = (op.kind == kip_pkg::OP_MULS) ? ((seed_q >> 27) | 64'd1) : op.k;
		unique case (cmd.mul_ph)
			2'd0:    begin mul_x = v_q[31:0];  mul_y = mul_b[31:0];  end
			2'd1:    begin mul_x = v_q[63:32]; mul_y = mul_b[31:0];  end
			default: begin mul_x = v_q[31:0];  mul_y = mul_b[63:32]; end
		endcase
		prod = {32'd0, mul_x} * {32'd0, mul_y};
	end

	// result of one non-multiply op
	always_comb begin
		unique case (op.kind)
			kip_pkg::OP_XS:  v_nxt = v_q ^ (seed_q >> op.sh);
			kip_pkg::OP_XM:  v_nxt = v_q ^ ((v_q & mask_w) >> op.sh);
			kip_pkg::OP_AND: v_nxt = v_q & mask_w;
			default:         v_nxt = v_q;
		endcase
	end

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			len_q  <= 63'd1;
			seed_q <= 64'd0;
			mask_q <= 63'd0;
		end else if (cfg_we) begin
			if (cfg_index == kip_pkg::REG_LENGTH) begin
				len_q  <= cfg_data[62:0];
				mask_q <= make_mask(cfg_data[62:0]);
			end else if (cfg_index == kip_pkg::REG_SEED) begin
				seed_q <= cfg_data;
			end
		end
	end

	// working value, remainder and multiply accumulator
	always_ff @(posedge clk) begin
		if (cmd.load) begin
			neg_q <= source_index[63];
			dvd_q <= source_index[63] ? (64'd0 - source_index) : source_index;
			rem_q <= 64'd0;
		end else if (cmd.div_step) begin
			rem_q <= (trial >= len_w) ? (trial - len_w) : trial;
			dvd_q <= {dvd_q[62:0], 1'b0};
		end

		if (cmd.zero) begin
			v_q <= 64'd0;
		end else if (cmd.fix) begin
			v_q <= (neg_q && rem_q != 64'd0) ? (len_w - rem_q) : rem_q;
		end else if (cmd.mix) begin
			if (op.kind == kip_pkg::OP_MUL || op.kind == kip_pkg::OP_MULS) begin
				unique case (cmd.mul_ph)
					2'd0:    acc_q <= prod;
					2'd1:    acc_q <= {acc_q[63:32] + prod[31:0], acc_q[31:0]};
					default: v_q   <= {acc_q[63:32] + prod[31:0], acc_q[31:0]};
				endcase
			end else begin
				v_q <= v_nxt;
			end
		end
	end

endmodule

// ===== sv/kip_ctrl.sv =====
module kip_ctrl (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          start,
	output logic          busy,
	output logic          done,
	output kip_pkg::cmd_t cmd,
	input  kip_pkg::sts_t sts
);

	typedef enum logic [4:0] {
		ST_IDLE = 5'b00001,
		ST_DIV  = 5'b00010,
		ST_FIX  = 5'b00100,
		ST_MIX  = 5'b01000,
		ST_DONE = 5'b10000
	} state_t;

	localparam logic [kip_pkg::OP_W-1:0] LastOp = kip_pkg::OP_W'(kip_pkg::NUM_OPS - 1);

	state_t                      state_q;
	logic [kip_pkg::DIV_W-1:0]   div_q;
	logic [kip_pkg::OP_W-1:0]    op_q;
	logic [1:0]                  ph_q;
	logic                        chk_q;
	kip_pkg::op_t                op;
	logic                        is_mul;
	logic                        op_end;

	assign op     = kip_pkg::op_rom(op_q);
	assign is_mul = (op.kind == kip_pkg::OP_MUL) || (op.kind == kip_pkg::OP_MULS);
	assign op_end = !is_mul || (ph_q == 2'd2);

	assign busy = (state_q != ST_IDLE);
	assign done = (state_q == ST_DONE);

	always_comb begin
		cmd          = '0;
		cmd.load     = (state_q == ST_IDLE) && start;
		cmd.zero     = (state_q == ST_IDLE) && start && sts.len_zero;
		cmd.div_step = (state_q == ST_DIV);
		cmd.fix      = (state_q == ST_FIX);
		cmd.mix      = (state_q == ST_MIX) && !chk_q;
		cmd.op_idx   = op_q;
		cmd.mul_ph   = ph_q;
	end

	// sequence: remainder, wrap, mix passes until in range
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			div_q   <= '0;
			op_q    <= '0;
			ph_q    <= 2'd0;
			chk_q   <= 1'b0;
		end else begin
			unique case (state_q)
				ST_IDLE: begin
					if (start) begin
						div_q   <= '0;
						state_q <= sts.len_zero ? ST_DONE : ST_DIV;
					end
				end
				ST_DIV: begin
					div_q <= div_q + kip_pkg::DIV_W'(1);
					if (&div_q) begin
						state_q <= ST_FIX;
					end
				end
				ST_FIX: begin
					op_q    <= '0;
					ph_q    <= 2'd0;
					chk_q   <= 1'b0;
					state_q <= ST_MIX;
				end
				ST_MIX: begin
					if (chk_q) begin
						// walk again while the value is out of range
						chk_q <= 1'b0;
						op_q  <= '0;
						if (sts.below_len) begin
							state_q <= ST_DONE;
						end
					end else if (op_end) begin
						ph_q <= 2'd0;
						if (op_q == LastOp) begin
							chk_q <= 1'b1;
						end else begin
							op_q <= op_q + kip_pkg::OP_W'(1);
						end
					end else begin
						ph_q <= ph_q + 2'd1;
					end
				end
				ST_DONE: begin
					state_q <= ST_IDLE;
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

endmodule
